[rtl/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and helpers for the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_REPL    = 8;
  localparam int LEN_W       = 4;
  localparam int CNT_W       = $clog2(MAX_PATTERN + 2);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int IDX_W       = $clog2(MAX_REPL);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PATTERN     = 2'd0,
    REG_PATTERN_LEN = 2'd1,
    REG_REPL        = 2'd2,
    REG_REPL_LEN    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [8*MAX_PATTERN-1:0] pattern;
    logic [LEN_W-1:0]         pattern_len;
    logic [8*MAX_REPL-1:0]    replacement;
    logic [LEN_W-1:0]         replacement_len;
  } cfg_t;

  // One queued burst of output bytes
  typedef struct packed {
    logic [8*MAX_REPL-1:0] bytes;
    logic [LEN_W-1:0]      len;   // 1..8
    logic                  last;  // burst ends the stream
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Length register clamp: zero acts as one, above max acts as max.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                 input logic [LEN_W-1:0] max_len);
    logic [LEN_W-1:0] r;
    r = len;
    if (r == '0) r = LEN_W'(1);
    if (r > max_len) r = max_len;
    return r;
  endfunction

endpackage

[rtl/sfr_front.sv]
// ----------------------------------------------------------------------------
// sfr_front
// Window keeper and matcher: takes one byte per transfer, compares the window
// against the pattern and issues one output burst command when bytes leave.
// ----------------------------------------------------------------------------
module sfr_front
  import sfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  cfg_t             cfg,
  output logic             push,
  output cmd_t             cmd,
  output logic [CNT_W-1:0] win_count
);

  logic [7:0]       win [0:MAX_PATTERN-1];
  logic [7:0]       ext [0:MAX_PATTERN];
  logic [CNT_W-1:0] cnt_inc;
  logic [LEN_W-1:0] plen;
  logic [LEN_W-1:0] rlen;
  logic [MAX_PATTERN-1:0] byte_ok;
  logic             match;
  logic             at_len;
  logic             pop;
  logic [CNT_W-1:0] win_count_next;

  always_comb begin
    plen    = clamp_len(cfg.pattern_len, LEN_W'(MAX_PATTERN));
    rlen    = clamp_len(cfg.replacement_len, LEN_W'(MAX_REPL));
    cnt_inc = win_count + CNT_W'(1);
    // window with the new byte appended at position win_count
    for (int i = 0; i < MAX_PATTERN; i++) begin
      ext[i] = (CNT_W'(i) < win_count) ? win[i] : in_byte;
    end
    ext[MAX_PATTERN] = in_byte;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      byte_ok[i] = (CNT_W'(i) >= CNT_W'(plen)) ||
                   (ext[i] == cfg.pattern[8*i +: 8]);
    end
    at_len = cnt_inc >= CNT_W'(plen);
    match  = (cnt_inc == CNT_W'(plen)) && (&byte_ok);
    pop    = at_len && !match;
  end

  always_comb begin
    cmd.bytes = '0;
    cmd.len   = LEN_W'(1);
    cmd.last  = in_last;
    push      = 1'b0;
    if (match) begin
      cmd.bytes = cfg.replacement;
      cmd.len   = rlen;
      push      = accept;
    end else if (in_last) begin
      // oldest byte plus flush of the rest, capped at eight results
      for (int i = 0; i < MAX_REPL; i++) begin
        cmd.bytes[8*i +: 8] = ext[i];
      end
      cmd.len = (cnt_inc > CNT_W'(MAX_REPL)) ? LEN_W'(MAX_REPL) : LEN_W'(cnt_inc);
      push    = accept;
    end else if (pop) begin
      cmd.bytes[7:0] = ext[0];
      push           = accept;
    end
  end

  always_comb begin
    if (in_last || match) begin
      win_count_next = '0;
    end else if (pop) begin
      win_count_next = win_count;
    end else begin
      win_count_next = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_count <= '0;
    end else if (accept) begin
      win_count <= win_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win[i] <= pop ? ext[i+1] : ext[i];
      end
    end
  end

endmodule

[rtl/sfr_queue.sv]
// ----------------------------------------------------------------------------
// sfr_queue
// Two-entry command FIFO between the matcher and the byte expander.
// ----------------------------------------------------------------------------
module sfr_queue
  import sfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  cmd_t              mem [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == QCNT_W'(QDEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) count <= count + QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/sfr_back.sv]
// ----------------------------------------------------------------------------
// sfr_back
// Byte expander: walks the head burst one byte per output transfer.
// ----------------------------------------------------------------------------
module sfr_back
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  q_status_t  q_status,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       stream_end
);

  logic [IDX_W-1:0] idx;
  logic [LEN_W-1:0] len_m1;
  logic             xfer;

  assign len_m1     = head.len - LEN_W'(1);
  assign out_valid  = !q_status.empty;
  assign out_byte   = head.bytes[8*idx +: 8];
  assign run_last   = (LEN_W'(idx) == len_m1);
  assign stream_end = run_last && head.last;
  assign xfer       = out_valid && out_ready;
  assign pop        = xfer && run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (xfer) begin
      idx <= run_last ? '0 : idx + IDX_W'(1);
    end
  end

endmodule

[rtl/stream_find_replace.sv]
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming literal find-and-replace on a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input bytes arrive on the s_* channel, one byte per transfer, s_tlast on
//   the final byte of a stream. Each leftmost, non-overlapping match of the
//   pattern (1..8 bytes) is replaced by the replacement string (1..8 bytes);
//   replaced text is not rescanned. On s_tlast all pending bytes are flushed.
//   Output bytes leave on m_*; m_tuser marks the last byte caused by one input
//   transfer, m_tlast the very last byte of the stream.
//   Configuration is written through cfg_we/cfg_index/cfg_data while the
//   block is idle; it applies from the next input transfer.
// Queueing and throughput:
//   Bursts are registered in the queue and leave from its head. Inputs
//   that cause zero or one byte go at one transfer per cycle while the queue
//   has room. An input that causes n bytes holds the expander for n transfers;
//   the matcher keeps running until the two-entry queue fills, then s_tready drops.
// Reset:
//   rst clears the window, the queue and the expander and loads pattern = 0,
//   pattern_len = 1, replacement = 0, replacement_len = 1.
// Stall:
//   A stalled m_tready holds the current byte; the input side stalls only
//   once the queue is full.
// ----------------------------------------------------------------------------
module stream_find_replace
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // in_last
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // stream_end
  output logic [0:0]  m_tuser,   // [0] run_last
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t             cfg;
  logic             accept;
  logic             push;
  cmd_t             push_cmd;
  cmd_t             head;
  q_status_t        q_status;
  logic             pop;
  logic [CNT_W-1:0] win_count;
  logic             run_last;

  // Configuration registers; length registers keep their low four bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern         <= '0;
      cfg.pattern_len     <= LEN_W'(1);
      cfg.replacement     <= '0;
      cfg.replacement_len <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PATTERN:     cfg.pattern         <= cfg_data;
        REG_PATTERN_LEN: cfg.pattern_len     <= cfg_data[LEN_W-1:0];
        REG_REPL:        cfg.replacement     <= cfg_data;
        REG_REPL_LEN:    cfg.replacement_len <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input is taken whenever the burst queue has room, even if the output
  // side is stalled.
  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;

  sfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .cfg       (cfg),
    .push      (push),
    .cmd       (push_cmd),
    .win_count (win_count)
  );

  sfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  sfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .run_last   (run_last),
    .stream_end (m_tlast)
  );

  assign m_tuser[0] = run_last;

  // Stream end is always the last byte of a run.
  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("stream end without run last");

  // The final input byte empties the window.
  a_last_clears_window: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> win_count == '0)
    else $error("window not cleared after last byte");

  // Window never holds more than the largest pattern.
  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    win_count <= CNT_W'(MAX_PATTERN))
    else $error("window overflow");

  // Output valid tracks a pending burst in the queue.
  a_valid_tracks_queue: assert property (@(posedge clk) disable iff (rst)
    accept && push && !m_tvalid |=> m_tvalid)
    else $error("pushed burst not presented");

endmodule
